// File: rtl/core/ascd_pkg.sv
package ascd_pkg;

    localparam int ASCD_CHAIN_WORDS = 38;
    localparam int DAC_WORD = 34;
    localparam int UPC_W = 4;

    localparam logic [5:0] PIN_IDLE = 6'h20;
    localparam logic [5:0] PIN_ZERO = 6'h21;
    localparam logic [5:0] PIN_PHI2 = 6'h04;
    localparam logic [5:0] PIN_PHI1 = 6'h02;
    localparam logic [5:0] PIN_LOAD = 6'h28;
    localparam logic [31:0] DAC_KEEP = 32'h8000_001F;
    localparam logic [31:0] TOP_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [10:0] bit_position;
        logic [4:0]  coarse_one;
        logic [4:0]  coarse_two;
        logic [4:0]  coarse_three;
        logic [4:0]  fine_tune;
        logic [4:0]  superfine_tune;
    } item_t;

    typedef struct packed {
        logic [5:0] drive_word;
        logic       read_bit;
        logic       busy_res;
        logic       rejected;
    } result_t;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_READ  = 3'd3,
        CMD_DAC   = 3'd4,
        CMD_SHIFT = 3'd5,
        CMD_LOAD  = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_ADVANCE   = 4'd1,
        OP_SET       = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_CAPTURE   = 4'd4,
        OP_DAC       = 4'd5,
        OP_ARM_SHIFT = 4'd6,
        OP_ARM_LOAD  = 4'd7,
        OP_REJECT    = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_ACCEPT   = 2'd1,
        COND_DISPATCH = 2'd2,
        COND_OUT_FREE = 2'd3
    } cond_t;

    typedef struct packed {
        logic             take;
        logic             rd;
        op_t              op;
        logic             emit;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] cmd;
        logic       busy;
        logic       pos_ok;
        logic       out_free;
    } status_t;

    localparam logic [UPC_W-1:0] UA_FETCH     = 4'd0;
    localparam logic [UPC_W-1:0] UA_READ      = 4'd1;
    localparam logic [UPC_W-1:0] UA_TICK      = 4'd2;
    localparam logic [UPC_W-1:0] UA_SET       = 4'd3;
    localparam logic [UPC_W-1:0] UA_CLEAR     = 4'd4;
    localparam logic [UPC_W-1:0] UA_RDBIT     = 4'd5;
    localparam logic [UPC_W-1:0] UA_DAC       = 4'd6;
    localparam logic [UPC_W-1:0] UA_ARM_SHIFT = 4'd7;
    localparam logic [UPC_W-1:0] UA_ARM_LOAD  = 4'd8;
    localparam logic [UPC_W-1:0] UA_REJECT    = 4'd9;
    localparam logic [UPC_W-1:0] UA_EMIT      = 4'd10;

    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        w = '{take: 1'b0, rd: 1'b0, op: OP_NONE, emit: 1'b0,
              cond: COND_ALWAYS, target: UA_EMIT};
        unique case (upc)
            UA_FETCH: begin
                w.take = 1'b1;
                w.cond = COND_ACCEPT;
                w.target = UA_READ;
            end
            UA_READ: begin
                w.rd = 1'b1;
                w.cond = COND_DISPATCH;
            end
            UA_TICK:      w.op = OP_ADVANCE;
            UA_SET:       w.op = OP_SET;
            UA_CLEAR:     w.op = OP_CLEAR;
            UA_RDBIT:     w.op = OP_CAPTURE;
            UA_DAC:       w.op = OP_DAC;
            UA_ARM_SHIFT: w.op = OP_ARM_SHIFT;
            UA_ARM_LOAD:  w.op = OP_ARM_LOAD;
            UA_REJECT:    w.op = OP_REJECT;
            UA_EMIT: begin
                w.emit = 1'b1;
                w.cond = COND_OUT_FREE;
                w.target = UA_FETCH;
            end
            default:      w.target = UA_FETCH;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] rev5(input logic [4:0] v);
        return {v[0], v[1], v[2], v[3], v[4]};
    endfunction

endpackage

// File: rtl/core/ascd_ram.sv
module ascd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 38,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ascd_useq.sv
module ascd_useq
    import ascd_pkg::*;
#(
    parameter int CHAIN_WORDS = ASCD_CHAIN_WORDS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output uword_t  ctrl
);

    localparam logic DAC_OK = (CHAIN_WORDS > DAC_WORD);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] entry;

    assign ctrl = ucode(upc_reg);

    always_comb begin
        entry = UA_REJECT;
        if (status.cmd == CMD_TICK) begin
            entry = UA_TICK;
        end else if (!status.busy) begin
            unique case (status.cmd)
                CMD_SET:   entry = status.pos_ok ? UA_SET : UA_REJECT;
                CMD_CLEAR: entry = status.pos_ok ? UA_CLEAR : UA_REJECT;
                CMD_READ:  entry = status.pos_ok ? UA_RDBIT : UA_REJECT;
                CMD_DAC:   entry = DAC_OK ? UA_DAC : UA_REJECT;
                CMD_SHIFT: entry = UA_ARM_SHIFT;
                CMD_LOAD:  entry = UA_ARM_LOAD;
                default:   entry = UA_REJECT;
            endcase
        end
    end

    always_comb begin
        upc_next = upc_reg;
        unique case (ctrl.cond)
            COND_ALWAYS:   upc_next = ctrl.target;
            COND_ACCEPT:   upc_next = status.in_valid ? ctrl.target : upc_reg;
            COND_DISPATCH: upc_next = entry;
            COND_OUT_FREE: upc_next = status.out_free ? ctrl.target : upc_reg;
            default:       upc_next = UA_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/core/ascd_datapath.sv
module ascd_datapath
    import ascd_pkg::*;
#(
    parameter int CHAIN_WORDS = ASCD_CHAIN_WORDS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  uword_t  ctrl,
    output status_t status,
    input  logic    s_valid,
    input  item_t   s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int WADDR_W = (CHAIN_WORDS > 1) ? $clog2(CHAIN_WORDS) : 1;
    localparam logic [11:0] TOTAL = 12'(CHAIN_WORDS * 32);
    localparam logic [10:0] TOP_POS = 11'(CHAIN_WORDS * 32 - 1);
    localparam logic [WADDR_W-1:0] DAC_ADDR = WADDR_W'(DAC_WORD);
    localparam logic [WADDR_W:0] DEPTH_LIM = (WADDR_W + 1)'(CHAIN_WORDS);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SHIFT = 3'b010,
        MODE_LOAD  = 3'b100
    } mode_t;

    item_t             item_reg;
    logic [WADDR_W-1:0] addr_reg;
    logic [WADDR_W-1:0] raddr;
    logic              rd_valid_reg;
    logic [CHAIN_WORDS-1:0] valid_reg;
    logic [31:0]       rd_data;
    logic [31:0]       image_word;
    logic [31:0]       bit_mask;
    logic [31:0]       wdata;
    logic              we;
    logic              raddr_ok;

    mode_t       mode_reg, mode_next;
    logic [2:0]  phase_reg, phase_next;
    logic [10:0] shift_idx_reg, shift_idx_next;
    logic [5:0]  pin_reg, pin_next;
    logic [5:0]  base;
    logic        read_bit_reg, read_bit_next;
    logic        rej_reg, rej_next;
    logic        m_valid_reg;
    result_t     result_reg;
    logic        out_free;
    logic        accept;

    assign accept = s_valid && ctrl.take;
    assign out_free = !m_valid_reg || m_ready;

    assign status.in_valid = s_valid;
    assign status.cmd = item_reg.cmd;
    assign status.busy = (mode_reg != MODE_IDLE);
    assign status.pos_ok = ({1'b0, item_reg.bit_position} < TOTAL);
    assign status.out_free = out_free;

    always_comb begin
        if (item_reg.cmd == CMD_TICK) begin
            raddr = WADDR_W'(shift_idx_reg[10:5]);
        end else if (item_reg.cmd == CMD_DAC) begin
            raddr = DAC_ADDR;
        end else begin
            raddr = WADDR_W'(item_reg.bit_position[10:5]);
        end
    end

    assign raddr_ok = ({1'b0, raddr} < DEPTH_LIM);

    ascd_ram #(
        .WIDTH(32),
        .DEPTH(CHAIN_WORDS)
    ) u_image (
        .aclk  (aclk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (wdata),
        .re    (ctrl.rd),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign image_word = rd_valid_reg ? rd_data : 32'h0;
    assign bit_mask = TOP_BIT >> item_reg.bit_position[4:0];
    assign base = image_word[~shift_idx_reg[4:0]] ? PIN_IDLE : PIN_ZERO;

    always_comb begin
        we = 1'b0;
        wdata = image_word;
        mode_next = mode_reg;
        phase_next = phase_reg;
        shift_idx_next = shift_idx_reg;
        pin_next = pin_reg;
        read_bit_next = read_bit_reg;
        rej_next = rej_reg;
        if (accept) begin
            read_bit_next = 1'b0;
            rej_next = 1'b0;
        end
        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_ADVANCE: begin
                if (mode_reg == MODE_SHIFT) begin
                    unique case (phase_reg)
                        3'd2:    pin_next = base | PIN_PHI2;
                        3'd4:    pin_next = base | PIN_PHI1;
                        default: pin_next = base;
                    endcase
                    if (phase_reg >= 3'd4) begin
                        phase_next = 3'd0;
                        if (shift_idx_reg == 11'd0) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            shift_idx_next = shift_idx_reg - 11'd1;
                        end
                    end else begin
                        phase_next = phase_reg + 3'd1;
                    end
                end else if (mode_reg == MODE_LOAD) begin
                    if (phase_reg == 3'd0) begin
                        pin_next = PIN_LOAD;
                        phase_next = 3'd1;
                    end else begin
                        pin_next = PIN_IDLE;
                        phase_next = 3'd0;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            OP_SET: begin
                we = 1'b1;
                wdata = image_word | bit_mask;
            end
            OP_CLEAR: begin
                we = 1'b1;
                wdata = image_word & ~bit_mask;
            end
            OP_CAPTURE: begin
                read_bit_next = |(image_word & bit_mask);
            end
            OP_DAC: begin
                we = 1'b1;
                wdata = (image_word & DAC_KEEP)
                      | {1'b0, rev5(item_reg.coarse_one), rev5(item_reg.coarse_two),
                         rev5(item_reg.coarse_three), rev5(item_reg.fine_tune),
                         rev5(item_reg.superfine_tune), 1'b1, 5'b0};
            end
            OP_ARM_SHIFT: begin
                mode_next = MODE_SHIFT;
                shift_idx_next = TOP_POS;
                phase_next = 3'd0;
            end
            OP_ARM_LOAD: begin
                mode_next = MODE_LOAD;
                phase_next = 3'd0;
            end
            OP_REJECT: begin
                rej_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (ctrl.rd) begin
            addr_reg <= raddr;
        end
        if (ctrl.emit && out_free) begin
            result_reg.drive_word <= pin_reg;
            result_reg.read_bit <= read_bit_reg;
            result_reg.busy_res <= (mode_reg != MODE_IDLE);
            result_reg.rejected <= rej_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            mode_reg <= MODE_IDLE;
            phase_reg <= 3'd0;
            shift_idx_reg <= 11'd0;
            pin_reg <= PIN_IDLE;
            read_bit_reg <= 1'b0;
            rej_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (ctrl.rd) begin
                rd_valid_reg <= raddr_ok && valid_reg[raddr];
            end
            mode_reg <= mode_next;
            phase_reg <= phase_next;
            shift_idx_reg <= shift_idx_next;
            pin_reg <= pin_next;
            read_bit_reg <= read_bit_next;
            rej_reg <= rej_next;
            if (ctrl.emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result = result_reg;

endmodule

// File: rtl/core/analog_scan_chain_driver.sv
// Drives an analog scan chain from a 32-bit-word image of CHAIN_WORDS words held in a
// small RAM (chain position p is word p/32, bit 31 - p mod 32) and cleared at reset by
// per-word valid bits, so no clearing pass is needed. Every transfer gives exactly one
// result transfer. Each transfer runs a short microprogram of four steps: take the
// transfer, read one image word, apply the command, and load the output register; the
// output register is loaded only once the result side is free, and no new transfer is
// taken before the result of the last one has been loaded, so one image read is made per item.
// A tick advances a running shift or load sequence by one pin phase; a shift takes five
// ticks per chain bit and a load takes two.
module analog_scan_chain_driver
    import ascd_pkg::*;
#(
    parameter int CHAIN_WORDS = ASCD_CHAIN_WORDS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  item_t   s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    uword_t  ctrl;
    status_t status;

    ascd_useq #(
        .CHAIN_WORDS(CHAIN_WORDS)
    ) u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    ascd_datapath #(
        .CHAIN_WORDS(CHAIN_WORDS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_valid  (s_valid),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign s_ready = ctrl.take;

endmodule

// File: rtl/core/ascd_checker.sv
module ascd_checker
    import ascd_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_result
);

    // A result that waits must hold its value until the transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the item was processed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.rejected |-> !m_result.read_bit)
        else $error("rejected command returned a read bit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_result.drive_word[1] && m_result.drive_word[2]))
        else $error("phi1 and phi2 driven together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.drive_word[3] |-> m_result.drive_word[2:0] == 3'b000)
        else $error("load pulse overlaps a clock or data phase");

endmodule

bind analog_scan_chain_driver ascd_checker u_ascd_checker (.*);
